/* sv/hpt_pkg.sv */
`timescale 1ns / 1ps
package hpt_pkg;

    localparam int unsigned SLOTS = 8;
    localparam int unsigned SLOT_W = 3;
    localparam int unsigned WORD_W = 64;

    // Flag bit positions
    localparam int unsigned B_VALID  = 0;
    localparam int unsigned B_HIDE   = 1;
    localparam int unsigned B_WIRED  = 3;
    localparam int unsigned B_LOCKED = 6;
    localparam int unsigned B_CHG    = 7;
    localparam int unsigned B_REF    = 8;

    localparam logic [13:0] VCOUNT_MAX = 14'd16383;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_UNSET  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_CHANGE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_PRIMARY   = 3'd0,
        ST_SECONDARY = 3'd1,
        ST_EVICTED   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_SLOT_DONE = 3'd4
    } status_t;

    // Per-slot summary of one group
    typedef struct packed {
        logic [SLOTS-1:0] free;
        logic [SLOTS-1:0] cand;
        logic [SLOTS-1:0] refd;
    } grp_info_t;

endpackage

/* sv/hpt_group_mem.sv */
`timescale 1ns / 1ps
// One group of entries per row; read data registered; one write per cycle, to any selected slots of a row.
module hpt_group_mem import hpt_pkg::*; #(
    parameter int unsigned NUM_GROUPS = 1024,
    parameter int unsigned GW = 10
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [GW-1:0]            rd_addr,
    output logic [SLOTS*WORD_W-1:0]  rd_hi,
    output logic [SLOTS*WORD_W-1:0]  rd_lo,
    input  logic                     wr_en,
    input  logic [GW-1:0]            wr_addr,
    input  logic [SLOTS-1:0]         wr_sel,
    input  logic [SLOTS*WORD_W-1:0]  wr_hi,
    input  logic [SLOTS*WORD_W-1:0]  wr_lo
);

    logic [SLOTS*WORD_W-1:0] mem_hi [NUM_GROUPS];
    logic [SLOTS*WORD_W-1:0] mem_lo [NUM_GROUPS];

    // Write selected slots of a row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (wr_sel[i]) begin
                    mem_hi[wr_addr][i*WORD_W +: WORD_W] <= wr_hi[i*WORD_W +: WORD_W];
                    mem_lo[wr_addr][i*WORD_W +: WORD_W] <= wr_lo[i*WORD_W +: WORD_W];
                end
            end
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_hi <= mem_hi[rd_addr];
            rd_lo <= mem_lo[rd_addr];
        end
    end

endmodule

/* sv/hashed_page_table_insert_evict_core.sv */
`timescale 1ns / 1ps
// Hashed page table insert / evict core.
// Flow: the primary group read is captured in S_RD1 and the write made in S_EV1; when an
// insert finds no free slot there, it reads the secondary group and writes in S_EV2.
// One request at a time: s_ready stays low until the result is taken.
// Reset: after aresetn a clearing pass writes zero to every group, with s_ready low;
// counters clear at once and group_mask returns to 1023.
module hashed_page_table_insert_evict_core import hpt_pkg::*; #(
    parameter int unsigned NUM_GROUPS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [9:0]   cfg_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_cmd,
    input  logic [9:0]   s_group_index,
    input  logic [2:0]   s_slot,
    input  logic [63:0]  s_pte_hi,
    input  logic [63:0]  s_pte_lo,
    input  logic [63:0]  s_clear_mask,
    input  logic [63:0]  s_vpn,
    input  logic [2:0]   s_random_start,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [2:0]   m_status,
    output logic [2:0]   m_slot_used,
    output logic [9:0]   m_group_used,
    output logic [63:0]  m_entry_hi,
    output logic [63:0]  m_entry_lo,
    output logic [63:0]  m_evicted_hi,
    output logic [63:0]  m_evicted_lo,
    output logic         m_invalidate,
    output logic [47:0]  m_invalidate_address,
    output logic [13:0]  m_valid_count
);

    localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int unsigned RK = 20;
    localparam logic [31:0] RM = 32'((64'd1 << RK) / NUM_GROUPS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD1, S_EV1, S_RD2, S_EV2, S_OUT
    } state_t;

    state_t state_reg;
    logic [GW-1:0] clr_reg;
    logic [9:0]  gmask_reg;
    logic [13:0] vcnt_reg;
    logic [31:0] ovf_reg;

    // Captured request
    logic [1:0]  cmd_reg;
    logic [2:0]  slot_reg, rstart_reg;
    logic [63:0] phi_reg, plo_reg, cmask_reg, vpn_reg;
    logic [GW-1:0] pg_reg, sg_reg;
    grp_info_t   pinfo_reg;
    logic [SLOTS*WORD_W-1:0] prow_hi_reg, prow_lo_reg;

    // Result registers
    logic [2:0]  st_reg, sused_reg;
    logic [GW-1:0] gused_reg;
    logic [63:0] ehi_reg, elo_reg, vhi_reg, vlo_reg;
    logic        inv_reg;
    logic [47:0] iaddr_reg;

    // Memory ports
    logic rd_en, wr_en;
    logic [GW-1:0] rd_addr, wr_addr;
    logic [SLOTS-1:0] wr_sel;
    logic [SLOTS*WORD_W-1:0] rd_hi, rd_lo, wr_hi, wr_lo;

    hpt_group_mem #(.NUM_GROUPS(NUM_GROUPS), .GW(GW)) u_mem (
        .aclk(aclk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_hi(rd_hi), .rd_lo(rd_lo),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_sel(wr_sel), .wr_hi(wr_hi), .wr_lo(wr_lo)
    );

    // Reduce group number modulo NUM_GROUPS: reciprocal multiply, then one correction
    function automatic logic [GW-1:0] grp_mod(input logic [9:0] g);
        logic [31:0] gx, q, r;
        gx = 32'(g);
        q = (gx * RM) >> RK;
        r = gx - q * 32'(NUM_GROUPS);
        if (r >= 32'(NUM_GROUPS)) r = r - 32'(NUM_GROUPS);
        return GW'(r);
    endfunction

    // Summarize a group row
    function automatic grp_info_t summarize(input logic [SLOTS*WORD_W-1:0] hi,
                                            input logic [SLOTS*WORD_W-1:0] lo);
        grp_info_t r;
        logic [WORD_W-1:0] h, l;
        for (int i = 0; i < SLOTS; i++) begin
            h = hi[i*WORD_W +: WORD_W];
            l = lo[i*WORD_W +: WORD_W];
            r.free[i] = !h[B_VALID] && !h[B_LOCKED];
            r.cand[i] = !h[B_WIRED] && !h[B_LOCKED];
            r.refd[i] = l[B_REF];
        end
        return r;
    endfunction

    // Lowest free slot
    function automatic logic [2:0] first_free(input logic [SLOTS-1:0] f);
        logic [2:0] s;
        s = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (f[i]) s = 3'(i);
        end
        return s;
    endfunction

    // Victim scan from start: first unreferenced candidate, else last candidate
    function automatic logic [2:0] victim(input grp_info_t gi, input logic [2:0] start);
        logic [2:0] s, v;
        logic done;
        v = '0;
        done = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            s = start + 3'(j);
            if (!done && gi.cand[s]) begin
                v = s;
                if (!gi.refd[s]) done = 1'b1;
            end
        end
        return v;
    endfunction

    logic [63:0] new_hi, new_lo;
    grp_info_t   cur_info;
    logic [2:0]  cur_free, cur_vic, pri_vic, addr_slot;
    logic [63:0] cur_hi, cur_lo;
    logic [13:0] vc_dec_val, vc_inc_of_dec, vc_inc_val;

    always_comb begin
        cur_info  = summarize(rd_hi, rd_lo);
        cur_free  = first_free(cur_info.free);
        cur_vic   = victim(cur_info, rstart_reg);
        pri_vic   = victim(pinfo_reg, rstart_reg);
        addr_slot = slot_reg;
        cur_hi    = rd_hi[addr_slot*WORD_W +: WORD_W];
        cur_lo    = rd_lo[addr_slot*WORD_W +: WORD_W];
        vc_dec_val = (vcnt_reg != 14'd0) ? vcnt_reg - 14'd1 : vcnt_reg;
        vc_inc_of_dec = (vc_dec_val != VCOUNT_MAX) ? vc_dec_val + 14'd1 : vc_dec_val;
        vc_inc_val = (vcnt_reg != VCOUNT_MAX) ? vcnt_reg + 14'd1 : vcnt_reg;
    end

    assign cfg_ready = (state_reg != S_RD1) && (state_reg != S_RD2);
    assign s_ready   = (state_reg == S_IDLE);

    // Memory control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = grp_mod(s_group_index);
        wr_en   = 1'b0;
        wr_addr = pg_reg;
        wr_sel  = '0;
        wr_hi   = '0;
        wr_lo   = '0;
        new_hi  = '0;
        new_lo  = '0;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_sel  = '1;
            end
            S_IDLE: begin
                rd_en = s_valid;
            end
            S_EV1: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (pinfo_reg.free != '0) begin
                        wr_en = 1'b1;
                        wr_sel[first_free(pinfo_reg.free)] = 1'b1;
                        new_hi = (phi_reg & ~(64'd1 << B_HIDE)) | (64'd1 << B_VALID);
                        wr_hi = {SLOTS{new_hi}};
                        wr_lo = {SLOTS{plo_reg}};
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = sg_reg;
                    end
                end else begin
                    wr_en = 1'b1;
                    wr_sel[slot_reg] = 1'b1;
                    new_hi = prow_hi_reg[slot_reg*WORD_W +: WORD_W];
                    new_lo = prow_lo_reg[slot_reg*WORD_W +: WORD_W];
                    case (cmd_reg)
                        CMD_CLEAR: new_lo = new_lo & ~cmask_reg;
                        CMD_UNSET: new_hi = new_hi & ~(64'd1 << B_VALID);
                        default: begin
                            new_lo = plo_reg | (new_lo & ((64'd1 << B_REF) | (64'd1 << B_CHG)));
                            new_hi = phi_reg | (64'd1 << B_VALID);
                        end
                    endcase
                    wr_hi = {SLOTS{new_hi}};
                    wr_lo = {SLOTS{new_lo}};
                end
            end
            S_EV2: begin
                if (cur_info.free != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = sg_reg;
                    wr_sel[cur_free] = 1'b1;
                    new_hi = phi_reg | (64'd1 << B_HIDE) | (64'd1 << B_VALID);
                    wr_hi = {SLOTS{new_hi}};
                    wr_lo = {SLOTS{plo_reg}};
                end else if (pinfo_reg.cand != '0) begin
                    wr_en   = 1'b1;
                    wr_sel[pri_vic] = 1'b1;
                    new_hi = (phi_reg & ~(64'd1 << B_HIDE)) | (64'd1 << B_VALID);
                    wr_hi = {SLOTS{new_hi}};
                    wr_lo = {SLOTS{plo_reg}};
                end else if (cur_info.cand != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = sg_reg;
                    wr_sel[cur_vic] = 1'b1;
                    new_hi = phi_reg | (64'd1 << B_HIDE) | (64'd1 << B_VALID);
                    wr_hi = {SLOTS{new_hi}};
                    wr_lo = {SLOTS{plo_reg}};
                end
            end
            default: ;
        endcase
    end

    // Sequencer, counters and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            gmask_reg <= 10'd1023;
            vcnt_reg  <= '0;
            ovf_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) gmask_reg <= cfg_data;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + GW'(1);
                    if (clr_reg == GW'(NUM_GROUPS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_cmd;
                        slot_reg   <= s_slot;
                        rstart_reg <= s_random_start;
                        phi_reg    <= s_pte_hi;
                        plo_reg    <= s_pte_lo;
                        cmask_reg  <= s_clear_mask;
                        vpn_reg    <= s_vpn;
                        pg_reg     <= grp_mod(s_group_index);
                        sg_reg     <= grp_mod(s_group_index ^ gmask_reg);
                        state_reg  <= S_RD1;
                    end
                end
                S_RD1: begin
                    pinfo_reg   <= cur_info;
                    prow_hi_reg <= rd_hi;
                    prow_lo_reg <= rd_lo;
                    // Build the result: slot command, or insert into a free primary slot
                    sused_reg <= slot_reg;
                    gused_reg <= pg_reg;
                    vhi_reg   <= '0;
                    vlo_reg   <= '0;
                    if (cmd_reg != CMD_INSERT) begin
                        st_reg    <= ST_SLOT_DONE;
                        inv_reg   <= 1'b1;
                        iaddr_reg <= {vpn_reg[35:0], 12'd0};
                        elo_reg   <= plo_reg | (cur_lo & ((64'd1 << B_REF) | (64'd1 << B_CHG)));
                        case (cmd_reg)
                            CMD_CLEAR:  ehi_reg <= phi_reg;
                            CMD_UNSET: begin
                                ehi_reg  <= phi_reg & ~(64'd1 << B_VALID);
                                vcnt_reg <= vc_dec_val;
                            end
                            default: begin
                                ehi_reg  <= phi_reg | (64'd1 << B_VALID);
                                vcnt_reg <= vc_inc_of_dec;
                            end
                        endcase
                    end else begin
                        inv_reg   <= 1'b0;
                        iaddr_reg <= '0;
                        elo_reg   <= plo_reg;
                        ehi_reg   <= (phi_reg & ~(64'd1 << B_HIDE)) | (64'd1 << B_VALID);
                        if (cur_info.free != '0) begin
                            st_reg    <= ST_PRIMARY;
                            sused_reg <= cur_free;
                            vcnt_reg  <= vc_inc_val;
                        end
                    end
                    state_reg <= S_EV1;
                end
                S_EV1: begin
                    if (cmd_reg == CMD_INSERT && pinfo_reg.free == '0) begin
                        state_reg <= S_RD2;
                    end else begin
                        m_valid   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_RD2: state_reg <= S_EV2;
                S_EV2: begin
                    // Secondary free slot, then primary victim, then secondary victim, else overflow
                    if (cur_info.free != '0) begin
                        st_reg    <= ST_SECONDARY;
                        sused_reg <= cur_free;
                        gused_reg <= sg_reg;
                        ehi_reg   <= phi_reg | (64'd1 << B_HIDE) | (64'd1 << B_VALID);
                        vcnt_reg  <= vc_inc_val;
                    end else if (pinfo_reg.cand != '0) begin
                        st_reg    <= ST_EVICTED;
                        sused_reg <= pri_vic;
                        vhi_reg   <= prow_hi_reg[pri_vic*WORD_W +: WORD_W];
                        vlo_reg   <= prow_lo_reg[pri_vic*WORD_W +: WORD_W];
                        ovf_reg   <= ovf_reg + 32'd1;
                        vcnt_reg  <= vc_inc_of_dec;
                    end else if (cur_info.cand != '0) begin
                        st_reg    <= ST_EVICTED;
                        sused_reg <= cur_vic;
                        gused_reg <= sg_reg;
                        ehi_reg   <= phi_reg | (64'd1 << B_HIDE) | (64'd1 << B_VALID);
                        vhi_reg   <= rd_hi[cur_vic*WORD_W +: WORD_W];
                        vlo_reg   <= rd_lo[cur_vic*WORD_W +: WORD_W];
                        ovf_reg   <= ovf_reg + 32'd1;
                        vcnt_reg  <= vc_inc_of_dec;
                    end else begin
                        st_reg    <= ST_OVERFLOW;
                        sused_reg <= '0;
                        gused_reg <= '0;
                        ehi_reg   <= phi_reg;
                    end
                    m_valid   <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Drive result ports
    assign m_status             = st_reg;
    assign m_slot_used          = sused_reg;
    assign m_group_used         = 10'(gused_reg);
    assign m_entry_hi           = ehi_reg;
    assign m_entry_lo           = elo_reg;
    assign m_evicted_hi         = vhi_reg;
    assign m_evicted_lo         = vlo_reg;
    assign m_invalidate         = inv_reg;
    assign m_invalidate_address = iaddr_reg;
    assign m_valid_count        = vcnt_reg;

endmodule
